// ----- sv/mbc1_pkg.sv -----
// ----------------------------------------------------------------------------
// mbc1_pkg
// Shared command codes, queue request codes and the request type passed from
// the front end to the back end of the bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package mbc1_pkg;

  localparam int ROM_OFF_W = 21;
  localparam int RAM_OFF_W = 15;
  localparam int BANK_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int Q_DEPTH   = 2;

  localparam logic [2:0] CMD_ROM_RD  = 3'd0;
  localparam logic [2:0] CMD_REG_WR  = 3'd1;
  localparam logic [2:0] CMD_RAM_RD  = 3'd2;
  localparam logic [2:0] CMD_RAM_WR  = 3'd3;
  localparam logic [2:0] CMD_ROM_LD  = 3'd4;

  localparam logic [2:0] OP_ROM_RD   = 3'd0;
  localparam logic [2:0] OP_ROM_WR   = 3'd1;
  localparam logic [2:0] OP_RAM_RD   = 3'd2;
  localparam logic [2:0] OP_RAM_WR   = 3'd3;
  localparam logic [2:0] OP_BLOCKED  = 3'd4;

  localparam logic [1:0] CFG_MAPPER_MODE   = 2'd0;
  localparam logic [1:0] CFG_ROM_BANK_MASK = 2'd1;
  localparam logic [1:0] CFG_RAM_PRESENT   = 2'd2;
  localparam logic [1:0] CFG_RAM_BANK_MASK = 2'd3;

  localparam logic [1:0] REG_RAM_EN    = 2'd0;
  localparam logic [1:0] REG_ROM_BANK  = 2'd1;
  localparam logic [1:0] REG_UPPER     = 2'd2;
  localparam logic [1:0] REG_MODE      = 2'd3;

  localparam logic [7:0] BLOCKED_BYTE  = 8'hFF;
  localparam logic [3:0] RAM_EN_KEY    = 4'hA;

  typedef struct packed {
    logic [2:0]           op;
    logic [ROM_OFF_W-1:0] rom_addr;
    logic [RAM_OFF_W-1:0] ram_addr;
    logic [7:0]           data;
  } mbc1_req_t;

endpackage

`default_nettype wire

// ----- sv/mbc1_ram.sv -----
// ----------------------------------------------------------------------------
// mbc1_ram
// Generic single-port RAM with synchronous write and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc1_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 15
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [WIDTH-1:0]     wdata,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- sv/mbc1_front.sv -----
// ----------------------------------------------------------------------------
// mbc1_front
// Accepts bus requests, holds configuration and banking registers, applies
// register writes and turns memory accesses into physical requests.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc1_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mbc1_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mbc1_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [2:0]                       in_cmd,
  input  wire logic [15:0]                      in_bus_address,
  input  wire logic [7:0]                       in_write_data,
  input  wire logic [mbc1_pkg::ROM_OFF_W-1:0]   in_load_offset,
  input  wire logic                             q_full,
  input  wire logic                             clr_busy,
  output logic                                  q_push,
  output mbc1_pkg::mbc1_req_t                   q_req
);

  import mbc1_pkg::*;

  logic              mapper_mode_r;
  logic [BANK_W-1:0] rom_bank_mask_r;
  logic              ram_present_r;
  logic [1:0]        ram_bank_mask_r;
  logic              ram_enable_r, ram_enable_nxt;
  logic [4:0]        rom_bank_low_r, rom_bank_low_nxt;
  logic [1:0]        upper_bank_r, upper_bank_nxt;
  logic              advanced_mode_r, advanced_mode_nxt;

  logic              accept;
  logic              has_req;
  logic              ram_open;
  logic [BANK_W-1:0] rom_bank;
  logic [1:0]        ram_bank;
  logic [ROM_OFF_W-1:0] rom_off;
  logic [RAM_OFF_W-1:0] ram_off;

  assign in_ready = !q_full && !clr_busy;
  assign accept   = in_valid && in_ready;
  assign ram_open = ram_present_r && (!mapper_mode_r || ram_enable_r);

  always_comb begin
    if (!in_bus_address[14]) begin
      rom_bank = advanced_mode_r ? {upper_bank_r, 5'd0} : '0;
    end else begin
      rom_bank = {upper_bank_r, rom_bank_low_r};
    end
    rom_bank = rom_bank & rom_bank_mask_r;
    if (mapper_mode_r) begin
      rom_off = {rom_bank, in_bus_address[13:0]};
    end else begin
      rom_off = {6'd0, in_bus_address[14:0]};
    end
    ram_bank = (mapper_mode_r && advanced_mode_r) ? (upper_bank_r & ram_bank_mask_r) : 2'd0;
    ram_off  = {ram_bank, in_bus_address[12:0]};
  end

  always_comb begin
    has_req        = 1'b0;
    q_req.op       = OP_ROM_RD;
    q_req.rom_addr = rom_off;
    q_req.ram_addr = ram_off;
    q_req.data     = in_write_data;
    case (in_cmd)
      CMD_ROM_RD: begin
        has_req  = 1'b1;
        q_req.op = OP_ROM_RD;
      end
      CMD_RAM_RD: begin
        has_req  = 1'b1;
        q_req.op = ram_open ? OP_RAM_RD : OP_BLOCKED;
      end
      CMD_RAM_WR: begin
        has_req  = ram_open;
        q_req.op = OP_RAM_WR;
      end
      CMD_ROM_LD: begin
        has_req        = 1'b1;
        q_req.op       = OP_ROM_WR;
        q_req.rom_addr = in_load_offset;
      end
      default: begin
        has_req = 1'b0;
      end
    endcase
  end

  assign q_push = accept && has_req;

  // mbc1 register writes through the rom area
  always_comb begin
    ram_enable_nxt    = ram_enable_r;
    rom_bank_low_nxt  = rom_bank_low_r;
    upper_bank_nxt    = upper_bank_r;
    advanced_mode_nxt = advanced_mode_r;
    if (accept && in_cmd == CMD_REG_WR && mapper_mode_r) begin
      case (in_bus_address[14:13])
        REG_RAM_EN:   ram_enable_nxt = (in_write_data[3:0] == RAM_EN_KEY);
        REG_ROM_BANK: rom_bank_low_nxt = (in_write_data[4:0] == 5'd0) ? 5'd1
                                                                       : in_write_data[4:0];
        REG_UPPER:    upper_bank_nxt = in_write_data[1:0];
        REG_MODE:     advanced_mode_nxt = in_write_data[0];
        default:      ram_enable_nxt = ram_enable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r    <= 1'b0;
      rom_bank_low_r  <= 5'd1;
      upper_bank_r    <= 2'd0;
      advanced_mode_r <= 1'b0;
    end else begin
      ram_enable_r    <= ram_enable_nxt;
      rom_bank_low_r  <= rom_bank_low_nxt;
      upper_bank_r    <= upper_bank_nxt;
      advanced_mode_r <= advanced_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_mode_r   <= 1'b1;
      rom_bank_mask_r <= 7'h7F;
      ram_present_r   <= 1'b1;
      ram_bank_mask_r <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAPPER_MODE:   mapper_mode_r   <= cfg_wdata[0];
        CFG_ROM_BANK_MASK: rom_bank_mask_r <= cfg_wdata[BANK_W-1:0];
        CFG_RAM_PRESENT:   ram_present_r   <= cfg_wdata[0];
        CFG_RAM_BANK_MASK: ram_bank_mask_r <= cfg_wdata[1:0];
        default:           mapper_mode_r   <= mapper_mode_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/mbc1_queue.sv -----
// ----------------------------------------------------------------------------
// mbc1_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc1_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mbc1_pkg::mbc1_req_t push_req,
  output logic                     full,
  input  wire logic                pop,
  output mbc1_pkg::mbc1_req_t      head,
  output logic                     not_empty
);

  import mbc1_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  mbc1_req_t        entries_r [Q_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entries_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/mbc1_back.sv -----
// ----------------------------------------------------------------------------
// mbc1_back
// Executes queued requests against the rom and cartridge ram, clears the ram
// after reset and holds the read result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc1_back #(
  parameter int ROM_ADDR_BITS = 21,
  parameter int RAM_ADDR_BITS = 15
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire mbc1_pkg::mbc1_req_t q_head,
  output logic                     q_pop,
  output logic                     clr_busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_read_data,
  output logic                     out_ram_blocked
);

  import mbc1_pkg::*;

  logic                     clr_busy_r;
  logic [RAM_ADDR_BITS-1:0] clr_cnt_r;
  logic                     pend_r;
  logic [2:0]               pend_op_r;
  logic                     out_vld_r;
  logic [7:0]               out_data_r;
  logic                     out_blk_r;

  logic                     rom_we;
  logic [7:0]               rom_rdata;
  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;
  logic                     is_read;

  assign q_pop   = q_not_empty && !pend_r && !out_vld_r && !clr_busy_r;
  assign is_read = (q_head.op == OP_ROM_RD) || (q_head.op == OP_RAM_RD)
                || (q_head.op == OP_BLOCKED);

  assign rom_we    = q_pop && (q_head.op == OP_ROM_WR);
  assign ram_we    = clr_busy_r || (q_pop && (q_head.op == OP_RAM_WR));
  assign ram_addr  = clr_busy_r ? clr_cnt_r : q_head.ram_addr[RAM_ADDR_BITS-1:0];
  assign ram_wdata = clr_busy_r ? 8'd0 : q_head.data;

  mbc1_ram #(
    .WIDTH     (8),
    .ADDR_BITS (ROM_ADDR_BITS)
  ) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .addr  (q_head.rom_addr[ROM_ADDR_BITS-1:0]),
    .wdata (q_head.data),
    .rdata (rom_rdata)
  );

  mbc1_ram #(
    .WIDTH     (8),
    .ADDR_BITS (RAM_ADDR_BITS)
  ) u_cram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ram clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r <= q_pop && is_read;
      if (pend_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_op_r <= q_head.op;
    end
    if (pend_r) begin
      case (pend_op_r)
        OP_ROM_RD: begin
          out_data_r <= rom_rdata;
          out_blk_r  <= 1'b0;
        end
        OP_RAM_RD: begin
          out_data_r <= ram_rdata;
          out_blk_r  <= 1'b0;
        end
        default: begin
          out_data_r <= BLOCKED_BYTE;
          out_blk_r  <= 1'b1;
        end
      endcase
    end
  end

  assign clr_busy        = clr_busy_r;
  assign out_valid       = out_vld_r;
  assign out_read_data   = out_data_r;
  assign out_ram_blocked = out_blk_r;

endmodule

`default_nettype wire

// ----- sv/mbc1_cartridge_bank_mapper.sv -----
// ----------------------------------------------------------------------------
// mbc1_cartridge_bank_mapper
// MBC1 cartridge bank controller: banking registers, rom store and ram store.
// ----------------------------------------------------------------------------
// read path: queue, then the single read stage, then the output register
// flow: no request is popped while a read is in the read stage or waits in
//   the output register; otherwise writes and loads drain one per cycle
// reset: registers take their reset values, then the cartridge ram is cleared
//   address by address with in_ready low; the rom is not cleared
`default_nettype none

module mbc1_cartridge_bank_mapper #(
  parameter int ROM_ADDR_BITS = 21,
  parameter int RAM_ADDR_BITS = 15
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mbc1_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbc1_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_cmd,
  input  wire logic [15:0]                    in_bus_address,
  input  wire logic [7:0]                     in_write_data,
  input  wire logic [mbc1_pkg::ROM_OFF_W-1:0] in_load_offset,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_read_data,
  output logic                                out_ram_blocked
);

  import mbc1_pkg::*;

  mbc1_req_t push_req;
  mbc1_req_t head_req;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_not_empty;
  logic      clr_busy;

  mbc1_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_load_offset (in_load_offset),
    .q_full         (q_full),
    .clr_busy       (clr_busy),
    .q_push         (q_push),
    .q_req          (push_req)
  );

  mbc1_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (push_req),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_req),
    .not_empty (q_not_empty)
  );

  mbc1_back #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS),
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (head_req),
    .q_pop           (q_pop),
    .clr_busy        (clr_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_ram_blocked (out_ram_blocked)
  );

endmodule

`default_nettype wire

// ----- sv/mbc1_checker.sv -----
// ----------------------------------------------------------------------------
// mbc1_checker
// Port-level checks for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc1_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data,
  input wire logic       out_ram_blocked
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
                                 && $stable(out_ram_blocked))
    else $error("stalled result changed");

  // refused ram reads always read as all ones
  a_blocked_ff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ram_blocked |-> out_read_data == 8'hFF)
    else $error("blocked read without 0xff");

  // ram clearing keeps requests out right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during ram clear");

  // no result straight out of reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mbc1_cartridge_bank_mapper mbc1_checker u_mbc1_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_data   (out_read_data),
  .out_ram_blocked (out_ram_blocked)
);

`default_nettype wire
